// ----- rtl/ppbld_pkg.sv -----
// Shared types and constants for the push/pull button LED dimmer.
// Holds beat payload structs, phase and action codes, and dimmer state.
// No dependencies.
package ppbld_pkg;

  // Default ceiling on the speed setting
  localparam int MAX_SPEED_DEF = 10;

  // Button timing, in millisecond ticks
  localparam logic [10:0] HOLD_MS     = 11'd2000;
  localparam logic [10:0] LONG_MS     = 11'd500;
  localparam logic [10:0] ELAPSED_MAX = 11'd2047;

  // Step delays, in millisecond ticks
  localparam logic [6:0] DELAY_SLOW_MS = 7'd25;
  localparam logic [6:0] DELAY_MID_MS  = 7'd10;
  localparam logic [6:0] DELAY_FAST_MS = 7'd5;
  localparam logic [6:0] DELAY_TOP_MS  = 7'd3;

  // Levels
  localparam logic [7:0] LEVEL_FULL = 8'd255;
  localparam logic [7:0] LEVEL_HALF = 8'd127;

  typedef enum logic [2:0] {
    PH_OFF       = 3'd0,
    PH_ON        = 3'd1,
    PH_DOWN      = 3'd2,
    PH_UP        = 3'd3,
    PH_SLOW_UP   = 3'd4,
    PH_SLOW_DOWN = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_REQUEST = 2'd1,
    ACT_SET     = 2'd2,
    ACT_TOGGLE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_SPEED = 2'd0,
    REG_SLOW  = 2'd1,
    REG_FULL  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] level;
    logic [2:0] phase;
    logic       settled;
  } out_item_t;

  typedef struct packed {
    logic [3:0] dimming_speed;
    logic       slow_dimming_enable;
    logic       full_brightness_enable;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  current_level;
    logic [7:0]  target_level;
    logic [7:0]  remembered_level;
    phase_t      dim_phase;
    logic [6:0]  step_countdown;
    logic [10:0] press_elapsed;
    logic        button_prev;
  } dim_state_t;

  // Slow bouncing phases
  function automatic logic is_slow(phase_t ph);
    is_slow = (ph == PH_SLOW_UP) || (ph == PH_SLOW_DOWN);
  endfunction

  // Off, on, and the unused codes count as idle
  function automatic logic is_idle(phase_t ph);
    is_idle = !((ph == PH_DOWN) || (ph == PH_UP) || is_slow(ph));
  endfunction

endpackage

// ----- rtl/ppbld_step.sv -----
// Next-state logic of the dimmer: one item against the current state.
// Button edges, press timing, level requests and one fade step.
// Depends on ppbld_pkg.
module ppbld_step #(
  parameter int MAX_SPEED = ppbld_pkg::MAX_SPEED_DEF
) (
  input  ppbld_pkg::dim_state_t state_cur,
  input  ppbld_pkg::cfg_t       cfg,
  input  ppbld_pkg::in_item_t   item,
  output ppbld_pkg::dim_state_t state_nxt,
  output ppbld_pkg::out_item_t  result
);

  // Width that holds ten times the largest speed factor, and a level
  localparam int TW = $clog2(10 * (MAX_SPEED + 1) + 1);
  localparam int CW = (TW > 8) ? TW : 8;

  logic [CW-1:0] spd;
  logic [CW-1:0] fac;
  logic [CW-1:0] thr2;
  logic [CW-1:0] thr5;
  logic [CW-1:0] thr10;

  // Speed factor thresholds depend only on configuration
  always_comb begin
    if (CW'(cfg.dimming_speed) > CW'(MAX_SPEED)) begin
      spd = CW'(MAX_SPEED);
    end else begin
      spd = CW'(cfg.dimming_speed);
    end
    fac   = CW'(MAX_SPEED + 1) - spd;
    thr2  = fac << 1;
    thr5  = (fac << 2) + fac;
    thr10 = (fac << 3) + (fac << 1);
  end

  // Start a fade toward v unless bouncing or already there
  function automatic ppbld_pkg::dim_state_t request_level(ppbld_pkg::dim_state_t s,
                                                         logic [7:0] v);
    ppbld_pkg::dim_state_t r;
    r = s;
    if (!ppbld_pkg::is_slow(s.dim_phase) && (v != s.current_level)) begin
      r.step_countdown = '0;
      r.dim_phase      = (v < s.current_level) ? ppbld_pkg::PH_DOWN : ppbld_pkg::PH_UP;
      r.target_level   = v;
    end
    return r;
  endfunction

  function automatic ppbld_pkg::dim_state_t set_on(ppbld_pkg::dim_state_t s, logic on);
    logic [7:0] v;
    if (on) begin
      v = (s.remembered_level != '0) ? s.remembered_level : ppbld_pkg::LEVEL_FULL;
    end else begin
      v = '0;
    end
    return request_level(s, v);
  endfunction

  function automatic ppbld_pkg::dim_state_t toggle_light(ppbld_pkg::dim_state_t s);
    return set_on(s, (s.dim_phase == ppbld_pkg::PH_OFF) ||
                     (s.dim_phase == ppbld_pkg::PH_DOWN));
  endfunction

  // Move the level one count along the current phase
  function automatic ppbld_pkg::dim_state_t fade_step(ppbld_pkg::dim_state_t s);
    ppbld_pkg::dim_state_t r;
    r = s;
    case (s.dim_phase)
      ppbld_pkg::PH_DOWN: begin
        if (r.current_level > r.target_level) begin
          r.current_level = r.current_level - 8'd1;
        end
        if (r.current_level <= r.target_level) begin
          r.current_level = r.target_level;
          if (r.target_level != '0) begin
            r.remembered_level = r.target_level;
            r.dim_phase        = ppbld_pkg::PH_ON;
          end else begin
            r.dim_phase = ppbld_pkg::PH_OFF;
          end
        end
      end
      ppbld_pkg::PH_UP: begin
        if (r.current_level < r.target_level) begin
          r.current_level = r.current_level + 8'd1;
        end
        if (r.current_level >= r.target_level) begin
          r.current_level    = r.target_level;
          r.remembered_level = r.target_level;
          r.dim_phase        = ppbld_pkg::PH_ON;
        end
      end
      ppbld_pkg::PH_SLOW_UP: begin
        if (r.current_level == ppbld_pkg::LEVEL_FULL) begin
          r.current_level = 8'd254;
          r.dim_phase     = ppbld_pkg::PH_SLOW_DOWN;
        end else begin
          r.current_level = r.current_level + 8'd1;
        end
      end
      ppbld_pkg::PH_SLOW_DOWN: begin
        if (r.current_level == 8'd1) begin
          r.current_level = 8'd2;
          r.dim_phase     = ppbld_pkg::PH_SLOW_UP;
        end else if (r.current_level != '0) begin
          r.current_level = r.current_level - 8'd1;
        end
      end
      default: begin
        r = s;
      end
    endcase
    return r;
  endfunction

  ppbld_pkg::dim_state_t s;
  logic                  btn;
  logic                  slow_en;
  logic                  full_en;
  logic                  settled;
  logic [6:0]            dly;
  logic [CW-1:0]         lvl_w;

  always_comb begin
    s       = state_cur;
    btn     = item.value[0];
    slow_en = cfg.slow_dimming_enable;
    full_en = cfg.full_brightness_enable;
    settled = 1'b0;
    dly     = ppbld_pkg::DELAY_TOP_MS;
    lvl_w   = '0;
    case (item.action)
      ppbld_pkg::ACT_TICK: begin
        // Advance the press timer and the step countdown
        if (s.press_elapsed < ppbld_pkg::ELAPSED_MAX) begin
          s.press_elapsed = s.press_elapsed + 11'd1;
        end
        if (s.step_countdown != '0) begin
          s.step_countdown = s.step_countdown - 7'd1;
        end
        // Button edges and hold detection
        if (btn && !s.button_prev) begin
          if (!slow_en && !full_en) begin
            s = toggle_light(s);
          end else begin
            s.press_elapsed = '0;
          end
        end else if (btn && s.button_prev && (s.press_elapsed > ppbld_pkg::HOLD_MS)) begin
          if (!ppbld_pkg::is_slow(s.dim_phase) && slow_en) begin
            s.step_countdown = '0;
            s.dim_phase      = (s.current_level > ppbld_pkg::LEVEL_HALF) ?
                               ppbld_pkg::PH_SLOW_DOWN : ppbld_pkg::PH_SLOW_UP;
          end
        end else if (!btn && s.button_prev) begin
          if (ppbld_pkg::is_slow(s.dim_phase) && slow_en) begin
            s.target_level     = s.current_level;
            s.remembered_level = s.current_level;
            s.dim_phase        = ppbld_pkg::PH_ON;
          end else if ((s.press_elapsed > ppbld_pkg::LONG_MS) && full_en) begin
            s = request_level(s, ppbld_pkg::LEVEL_FULL);
          end else if (slow_en || full_en) begin
            s = toggle_light(s);
          end
        end
        s.button_prev = btn;
        // Take one fade step when the countdown has run out
        if (!ppbld_pkg::is_idle(s.dim_phase) && (s.step_countdown == '0)) begin
          s     = fade_step(s);
          lvl_w = CW'(s.current_level);
          if (lvl_w < thr2) begin
            dly = ppbld_pkg::DELAY_SLOW_MS;
          end else if (lvl_w < thr5) begin
            dly = ppbld_pkg::DELAY_MID_MS;
          end else if (lvl_w < thr10) begin
            dly = ppbld_pkg::DELAY_FAST_MS;
          end else begin
            dly = ppbld_pkg::DELAY_TOP_MS;
          end
          if (ppbld_pkg::is_slow(s.dim_phase)) begin
            dly = (dly << 1) + dly;
          end
          s.step_countdown = dly;
          settled          = ppbld_pkg::is_idle(s.dim_phase);
        end
      end
      ppbld_pkg::ACT_REQUEST: begin
        s = request_level(s, item.value);
      end
      ppbld_pkg::ACT_SET: begin
        s = set_on(s, item.value != '0);
      end
      default: begin
        s = toggle_light(s);
      end
    endcase
  end

  assign state_nxt      = s;
  assign result.level   = s.current_level;
  assign result.phase   = s.dim_phase;
  assign result.settled = settled;

endmodule

// ----- rtl/push_pull_button_led_dimmer_top.sv -----
// Top level of the push/pull button LED dimmer: handshakes, registers.
// Instantiates ppbld_step; depends on ppbld_pkg.
//
//   channel | direction | payload              | beat taken when
//   in_     | input     | action, value        | in_valid & in_ready
//   out_    | output    | level, phase, settled| out_valid & out_ready
//   cfg_    | input     | index, 4-bit data    | cfg_valid & cfg_ready
//
// Each item passes from the input beat through the input register, then
// through the step logic into the result register, to the result beat. One
// item enters per cycle while the result is not stalled; the dimmer state
// register updates on the same edge that loads the result. A stalled result
// holds the result register; the input register takes at most one more item
// and then in_ready drops until out_ready returns. Reset (rst_n low, synchronous)
// clears valid flags, dimmer state and configuration; cfg_ready is always high.
module push_pull_button_led_dimmer_top #(
  parameter int MAX_SPEED = ppbld_pkg::MAX_SPEED_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ppbld_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ppbld_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [3:0]           cfg_data
);

  logic                  in_valid_r;
  ppbld_pkg::in_item_t   in_item_r;
  logic                  out_valid_r;
  ppbld_pkg::out_item_t  out_item_r;
  ppbld_pkg::dim_state_t state_r;
  ppbld_pkg::dim_state_t state_nxt;
  ppbld_pkg::cfg_t       cfg_r;
  ppbld_pkg::cfg_t       cfg_nxt;
  ppbld_pkg::out_item_t  result;
  logic                  advance;

  // Move an item into the result register when there is room
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;
  assign cfg_ready = 1'b1;

  ppbld_step #(
    .MAX_SPEED (MAX_SPEED)
  ) u_step (
    .state_cur (state_r),
    .cfg       (cfg_r),
    .item      (in_item_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  // Decode configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        ppbld_pkg::REG_SPEED: cfg_nxt.dimming_speed          = cfg_data;
        ppbld_pkg::REG_SLOW:  cfg_nxt.slow_dimming_enable    = cfg_data[0];
        ppbld_pkg::REG_FULL:  cfg_nxt.full_brightness_enable = cfg_data[0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r       <= '0;
      state_r     <= '{current_level:    '0,
                       target_level:     '0,
                       remembered_level: '0,
                       dim_phase:        ppbld_pkg::PH_OFF,
                       step_countdown:   '0,
                       press_elapsed:    '0,
                       button_prev:      1'b0};
    end else begin
      cfg_r <= cfg_nxt;
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

endmodule
